>>> rtl/core/pl420_pkg.sv
// Shared types and constants for the planar 4:2:0 to packed YUY2 converter.
// Holds the word structs, register indexes and size limits; no dependencies.

package pl420_pkg;

   // Size limits of one frame.
   localparam int unsigned MAX_PAIRS = 2048;
   localparam int unsigned MAX_ROWS  = 4096;

   // Widths of the configuration registers and of the position counters.
   localparam int unsigned WIDTH_W = 12;
   localparam int unsigned HEIGHT_W = 13;
   localparam int unsigned COL_W = 11;
   localparam int unsigned ROW_W = 12;
   localparam int unsigned CSR_DATA_W = 13;
   localparam int unsigned CSR_INDEX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_PAIRS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_ROWS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERLACED_MODE = 2'd2;

   // Register values after reset.
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd360;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   // Interlaced averaging needs at least this many rows.
   localparam logic [HEIGHT_W-1:0] MIN_INTERLACED_ROWS = 13'd12;

   // Input word: one pixel pair with near and far chroma.
   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] luma_second;
      logic [7:0] u_near;
      logic [7:0] v_near;
      logic [7:0] u_far;
      logic [7:0] v_far;
   } req_word_type;

   // Output word: one YUY2 pair with row and frame markers.
   typedef struct packed {
      logic [31:0] packed_pair;
      logic        row_end;
      logic        frame_end;
   } rsp_word_type;

   // Frame geometry derived from the registers.
   typedef struct packed {
      logic [COL_W-1:0] last_col;
      logic [ROW_W-1:0] last_row;
      logic [ROW_W-1:0] plain_row;
      logic             interlaced;
   } frame_cfg_type;

   // Per-pair decisions made at the input.
   typedef struct packed {
      logic use_avg;
      logic row_end;
      logic frame_end;
   } pos_flags_type;

endpackage

>>> rtl/core/pl420_csr.sv
// Configuration registers and derived frame geometry.
// Depends on pl420_pkg.

module pl420_csr
   import pl420_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output frame_cfg_type          frame_cfg
);

   logic [WIDTH_W-1:0]  width_ff;
   logic [WIDTH_W-1:0]  width_in;
   logic [HEIGHT_W-1:0] height_ff;
   logic [HEIGHT_W-1:0] height_in;
   logic                inter_ff;
   logic                inter_in;
   logic [WIDTH_W-1:0]  eff_width;
   logic [HEIGHT_W-1:0] sat_height;
   logic [HEIGHT_W-1:0] eff_height;
   logic                inter_ok;

   // Register writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      inter_in  = inter_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_WIDTH_PAIRS:     width_in  = csr_data[WIDTH_W-1:0];
            CSR_HEIGHT_ROWS:     height_in = csr_data[HEIGHT_W-1:0];
            CSR_INTERLACED_MODE: inter_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         inter_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         inter_ff  <= inter_in;
      end
   end

   // Clamp the width into one to the maximum pair count.
   always_comb begin
      if (width_ff == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_PAIRS)) begin
         eff_width = WIDTH_W'(MAX_PAIRS);
      end else begin
         eff_width = width_ff;
      end
   end

   // Saturate, round down to even (or to a multiple of four when interlaced), floor at two.
   always_comb begin
      if (height_ff > HEIGHT_W'(MAX_ROWS)) begin
         sat_height = HEIGHT_W'(MAX_ROWS);
      end else begin
         sat_height = height_ff;
      end
      if (inter_ff) begin
         eff_height = {sat_height[HEIGHT_W-1:2], 2'b00};
      end else begin
         eff_height = {sat_height[HEIGHT_W-1:1], 1'b0};
      end
      inter_ok = inter_ff && (eff_height >= MIN_INTERLACED_ROWS);
      if (eff_height < HEIGHT_W'(2)) begin
         eff_height = HEIGHT_W'(2);
      end
   end

   // Geometry limits used by the position tracker.
   always_comb begin
      logic [WIDTH_W-1:0]  col_lim;
      logic [HEIGHT_W-1:0] row_lim;
      logic [HEIGHT_W-1:0] plain_lim;
      col_lim   = eff_width - WIDTH_W'(1);
      row_lim   = eff_height - HEIGHT_W'(1);
      plain_lim = eff_height - HEIGHT_W'(2);
      frame_cfg.last_col   = col_lim[COL_W-1:0];
      frame_cfg.last_row   = row_lim[ROW_W-1:0];
      frame_cfg.plain_row  = plain_lim[ROW_W-1:0];
      frame_cfg.interlaced = inter_ok;
   end

endmodule

>>> rtl/core/pl420_pos.sv
// Column and row tracking and the chroma averaging decision for each pair.
// Depends on pl420_pkg.

module pl420_pos
   import pl420_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  frame_cfg_type frame_cfg,
   input  logic          advance,
   output pos_flags_type pos_flags
);

   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic             row_done;
   logic             frame_done;
   logic             average;

   // Row and frame ends; counters past the limits end at once.
   assign row_done   = col_ff >= frame_cfg.last_col;
   assign frame_done = row_done && (row_ff >= frame_cfg.last_row);

   // The last row pair stays plain. Progressive averages odd rows; interlaced
   // averages the middle two rows of each group of four, from row two on.
   always_comb begin
      if (row_ff >= frame_cfg.plain_row) begin
         average = 1'b0;
      end else if (!frame_cfg.interlaced) begin
         average = row_ff[0];
      end else if (row_ff < ROW_W'(2)) begin
         average = 1'b0;
      end else begin
         average = row_ff[1] ^ row_ff[0];
      end
   end

   assign pos_flags.use_avg   = average;
   assign pos_flags.row_end   = row_done;
   assign pos_flags.frame_end = frame_done;

   // Counter update on each accepted word.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (row_done) begin
            col_in = '0;
            row_in = frame_done ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

>>> rtl/core/pl420_pipe.sv
// Two-register datapath: input register, chroma mean and YUY2 packing, result register.
// Depends on pl420_pkg.

module pl420_pipe
   import pl420_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_word_type  req_word,
   input  pos_flags_type pos_flags,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_word_type  rsp_word
);

   logic          s1_valid_ff;
   logic          s1_valid_in;
   req_word_type  s1_word_ff;
   pos_flags_type s1_flags_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   rsp_word_type  out_word_ff;
   rsp_word_type  out_word_in;
   logic          out_free;
   logic          s1_free;
   logic [8:0]    u_sum;
   logic [8:0]    v_sum;
   logic [7:0]    u_sel;
   logic [7:0]    v_sel;

   // Each stage takes a word when empty or when its word moves on.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_ready = s1_free;

   // Input register.
   assign s1_valid_in = s1_free ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_free) begin
         s1_word_ff  <= req_word;
         s1_flags_ff <= pos_flags;
      end
   end

   // Floor mean of near and far chroma where the row calls for it.
   assign u_sum = {1'b0, s1_word_ff.u_near} + {1'b0, s1_word_ff.u_far};
   assign v_sum = {1'b0, s1_word_ff.v_near} + {1'b0, s1_word_ff.v_far};
   assign u_sel = s1_flags_ff.use_avg ? u_sum[8:1] : s1_word_ff.u_near;
   assign v_sel = s1_flags_ff.use_avg ? v_sum[8:1] : s1_word_ff.v_near;

   // Pack as Y0, U, Y1, V from the low byte up.
   always_comb begin
      out_word_in.packed_pair = {v_sel, s1_word_ff.luma_second, u_sel,
                                 s1_word_ff.luma_first};
      out_word_in.row_end     = s1_flags_ff.row_end;
      out_word_in.frame_end   = s1_flags_ff.frame_end;
   end

   // Result register.
   assign out_valid_in = out_free ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

>>> rtl/core/planar_420_to_packed_422.sv
// Top level of the planar 4:2:0 to packed YUY2 converter.
// Depends on pl420_pkg, pl420_csr, pl420_pos and pl420_pipe.
//
//   port group  direction  carries
//   req_*       in         one pixel pair with near and far chroma per word
//   rsp_*       out        one YUY2 word with row and frame end markers
//   csr_*       in         register writes: width, height, interlaced mode
//
// Each accepted word passes the input register and then the result register
// on its way to the result port; one word enters per cycle while req_ready is high.
// Reset clears both stage valids and the column and row counters and loads
// the register defaults. A stall on the result side fills the two registers
// before req_ready drops, so no word is lost or repeated.

module planar_420_to_packed_422
   import pl420_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_word_type           rsp_word,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   frame_cfg_type frame_cfg;
   pos_flags_type pos_flags;
   logic          advance;

   assign advance = req_valid && req_ready;

   // Registers and geometry.
   pl420_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .frame_cfg (frame_cfg)
   );

   // Position counters and chroma decision.
   pl420_pos u_pos (
      .clock     (clock),
      .reset     (reset),
      .frame_cfg (frame_cfg),
      .advance   (advance),
      .pos_flags (pos_flags)
   );

   // Datapath.
   pl420_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .pos_flags (pos_flags),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

>>> rtl/core/pl420_checker.sv
// Port-level checks for the planar 4:2:0 to packed YUY2 converter.
// Depends on pl420_pkg; bound to planar_420_to_packed_422.

module pl420_checker
   import pl420_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // A frame ends only on the last word of a row.
   a_frame_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_word.frame_end || rsp_word.row_end))
      else $error("frame end without row end");

   // Both stages are empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

   // The input only stalls when a finished word is waiting.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled with free result register");

   // A held result keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)))
      else $error("result word changed while stalled");

endmodule

bind planar_420_to_packed_422 pl420_checker u_pl420_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
